// ----- hw/rtl/bbs_pkg.sv -----
package bbs_pkg;

   localparam int VAL_W  = 20;   // Q3.16 state and load values
   localparam int FRAC_W = 17;   // Q1.16 damping and radius
   localparam int STEP_W = 16;   // Q0.16 time step
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam int MUL_A_W = VAL_W + 1;
   localparam int MUL_B_W = FRAC_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int FRAC_BITS = 16;
   localparam int RND_W = MUL_P_W - FRAC_BITS;
   localparam int SUM_W = RND_W + 1;
   localparam int EDGE_W = VAL_W + 2;

   localparam logic signed [SUM_W-1:0]   SUM_MIN  = -24'sd524288;
   localparam logic signed [SUM_W-1:0]   SUM_MAX  = 24'sd524287;
   localparam logic signed [MUL_P_W-1:0] RND_HALF = 39'sd32768;
   localparam logic signed [EDGE_W-1:0]  FIX_ONE  = 22'sd65536;

   localparam logic signed [VAL_W-1:0] GRAVITY_RST = -20'sd64225;
   localparam logic [FRAC_W-1:0]       DAMPING_RST = 17'd52429;
   localparam logic [FRAC_W-1:0]       RADIUS_RST  = 17'd3277;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [FRAC_W-1:0]       frac_type;
   typedef logic [STEP_W-1:0]       step_type;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } bbs_kind_type;

   typedef enum logic [1:0] {
      REG_GRAVITY = 2'd0,
      REG_DAMPING = 2'd1,
      REG_RADIUS  = 2'd2
   } bbs_reg_type;

   typedef enum logic [2:0] {
      MUL_VX_DT,
      MUL_VY_DT,
      MUL_G_DT,
      MUL_VX_DAMP,
      MUL_VY_DAMP
   } bbs_mul_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_G,
      ST_ADD_G,
      ST_WALL_X,
      ST_WALL_Y,
      ST_BOUNCE_Y,
      ST_OUT
   } bbs_state_type;

   typedef struct packed {
      val_type  gravity;
      frac_type damping;
      frac_type radius;
   } bbs_cfg_type;

   typedef struct packed {
      logic        load;
      logic        latch_step;
      bbs_mul_type mul_sel;
      logic        add_px;
      logic        add_py;
      logic        add_vy;
      logic        wall_x;
      logic        wall_y;
      logic        bounce_x;
      logic        bounce_y;
      logic        out_load;
   } bbs_cmd_type;

   typedef struct packed {
      logic out_free;
   } bbs_status_type;

   function automatic val_type sat_val(input logic signed [SUM_W-1:0] v);
      val_type r;
      if (v < SUM_MIN) begin
         r = SUM_MIN[VAL_W-1:0];
      end else if (v > SUM_MAX) begin
         r = SUM_MAX[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/bbs_if.sv -----
interface bbs_req_if;
   logic                  valid;
   logic                  ready;
   bbs_pkg::bbs_kind_type kind;
   bbs_pkg::step_type     time_step;
   bbs_pkg::val_type      load_x;
   bbs_pkg::val_type      load_y;
   bbs_pkg::val_type      load_vx;
   bbs_pkg::val_type      load_vy;

   modport source (output valid, kind, time_step, load_x, load_y, load_vx, load_vy,
                   input ready);
   modport sink (input valid, kind, time_step, load_x, load_y, load_vx, load_vy,
                 output ready);
endinterface

interface bbs_rsp_if;
   logic             valid;
   logic             ready;
   bbs_pkg::val_type pos_x;
   bbs_pkg::val_type pos_y;
   bbs_pkg::val_type vel_x;
   bbs_pkg::val_type vel_y;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// ----- hw/rtl/bbs_csr.sv -----
module bbs_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bbs_pkg::ADDR_W-1:0] paddr,
   input  logic [bbs_pkg::DATA_W-1:0] pwdata,
   output logic [bbs_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output bbs_pkg::bbs_cfg_type       cfg
);
   import bbs_pkg::*;

   bbs_cfg_type cfg_ff, cfg_in;
   bbs_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = bbs_reg_type'(paddr[3:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_GRAVITY: cfg_in.gravity = pwdata[VAL_W-1:0];
            REG_DAMPING: cfg_in.damping = pwdata[FRAC_W-1:0];
            REG_RADIUS:  cfg_in.radius  = pwdata[FRAC_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_GRAVITY: prdata = {{(DATA_W-VAL_W){cfg_ff.gravity[VAL_W-1]}}, cfg_ff.gravity};
         REG_DAMPING: prdata = {{(DATA_W-FRAC_W){1'b0}}, cfg_ff.damping};
         REG_RADIUS:  prdata = {{(DATA_W-FRAC_W){1'b0}}, cfg_ff.radius};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity <= GRAVITY_RST;
         cfg_ff.damping <= DAMPING_RST;
         cfg_ff.radius  <= RADIUS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/bbs_ctrl.sv -----
module bbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  bbs_pkg::bbs_kind_type   req_kind,
   output logic                    req_ready,
   input  bbs_pkg::bbs_status_type status,
   output bbs_pkg::bbs_cmd_type    cmd,
   output bbs_pkg::bbs_state_type  state
);
   import bbs_pkg::*;

   bbs_state_type state_ff, state_in;

   assign state = state_ff;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = MUL_VX_DT;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  cmd.latch_step = 1'b1;
                  state_in = ST_MUL_X;
               end
            end
         end
         ST_MUL_X: begin
            cmd.mul_sel = MUL_VX_DT;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_sel = MUL_VY_DT;
            cmd.add_px  = 1'b1;
            state_in = ST_MUL_G;
         end
         ST_MUL_G: begin
            cmd.mul_sel = MUL_G_DT;
            cmd.add_py  = 1'b1;
            state_in = ST_ADD_G;
         end
         ST_ADD_G: begin
            cmd.add_vy = 1'b1;
            state_in = ST_WALL_X;
         end
         ST_WALL_X: begin
            // bounce product is formed whether or not the wall is hit
            cmd.mul_sel = MUL_VX_DAMP;
            cmd.wall_x  = 1'b1;
            state_in = ST_WALL_Y;
         end
         ST_WALL_Y: begin
            cmd.mul_sel  = MUL_VY_DAMP;
            cmd.bounce_x = 1'b1;
            cmd.wall_y   = 1'b1;
            state_in = ST_BOUNCE_Y;
         end
         ST_BOUNCE_Y: begin
            cmd.bounce_y = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register frees up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/bbs_dp.sv -----
module bbs_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  bbs_pkg::bbs_cmd_type    cmd,
   output bbs_pkg::bbs_status_type status,
   input  bbs_pkg::bbs_cfg_type    cfg,
   input  bbs_pkg::step_type       req_time_step,
   input  bbs_pkg::val_type        req_load_x,
   input  bbs_pkg::val_type        req_load_y,
   input  bbs_pkg::val_type        req_load_vx,
   input  bbs_pkg::val_type        req_load_vy,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output bbs_pkg::val_type        rsp_pos_x,
   output bbs_pkg::val_type        rsp_pos_y,
   output bbs_pkg::val_type        rsp_vel_x,
   output bbs_pkg::val_type        rsp_vel_y
);
   import bbs_pkg::*;

   val_type  px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   step_type step_ff;
   logic signed [RND_W-1:0] prod_ff, prod_in;
   logic hit_x_ff, hit_x_in, hit_y_ff, hit_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   val_type out_px_ff, out_py_ff, out_vx_ff, out_vy_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p, mul_r;
   logic signed [SUM_W-1:0]   prod_ext;
   logic signed [EDGE_W-1:0]  r_ext;
   logic lo_x, hi_x, lo_y, hi_y;
   logic signed [EDGE_W-1:0]  lo_clamp, hi_clamp;

   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = out_px_ff;
   assign rsp_pos_y = out_py_ff;
   assign rsp_vel_x = out_vx_ff;
   assign rsp_vel_y = out_vy_ff;

   // shared multiplier, rounded to nearest Q6.16 with ties upward
   always_comb begin
      case (cmd.mul_sel)
         MUL_VX_DT:   mul_a = {vx_ff[VAL_W-1], vx_ff};
         MUL_VY_DT:   mul_a = {vy_ff[VAL_W-1], vy_ff};
         MUL_G_DT:    mul_a = {cfg.gravity[VAL_W-1], cfg.gravity};
         MUL_VX_DAMP: mul_a = -{vx_ff[VAL_W-1], vx_ff};
         MUL_VY_DAMP: mul_a = -{vy_ff[VAL_W-1], vy_ff};
         default:     mul_a = '0;
      endcase
      if (cmd.mul_sel == MUL_VX_DAMP || cmd.mul_sel == MUL_VY_DAMP) begin
         mul_b = $signed({1'b0, cfg.damping});
      end else begin
         mul_b = $signed({{(MUL_B_W-STEP_W){1'b0}}, step_ff});
      end
   end

   assign mul_p   = mul_a * mul_b;
   assign mul_r   = mul_p + RND_HALF;
   assign prod_in = mul_r[MUL_P_W-1:FRAC_BITS];
   assign prod_ext = {prod_ff[RND_W-1], prod_ff};

   // wall tests; the low edge wins when both fire
   assign r_ext = $signed({{(EDGE_W-FRAC_W){1'b0}}, cfg.radius});
   assign lo_x = ($signed({{2{px_ff[VAL_W-1]}}, px_ff}) - r_ext) < -FIX_ONE;
   assign hi_x = ($signed({{2{px_ff[VAL_W-1]}}, px_ff}) + r_ext) > FIX_ONE;
   assign lo_y = ($signed({{2{py_ff[VAL_W-1]}}, py_ff}) - r_ext) < -FIX_ONE;
   assign hi_y = ($signed({{2{py_ff[VAL_W-1]}}, py_ff}) + r_ext) > FIX_ONE;
   assign lo_clamp = r_ext - FIX_ONE;
   assign hi_clamp = FIX_ONE - r_ext;

   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      hit_x_in = hit_x_ff;
      hit_y_in = hit_y_ff;
      if (cmd.load) begin
         px_in = req_load_x;
         py_in = req_load_y;
         vx_in = req_load_vx;
         vy_in = req_load_vy;
      end
      if (cmd.add_px) begin
         px_in = sat_val({{(SUM_W-VAL_W){px_ff[VAL_W-1]}}, px_ff} + prod_ext);
      end
      if (cmd.add_py) begin
         py_in = sat_val({{(SUM_W-VAL_W){py_ff[VAL_W-1]}}, py_ff} + prod_ext);
      end
      if (cmd.add_vy) begin
         vy_in = sat_val({{(SUM_W-VAL_W){vy_ff[VAL_W-1]}}, vy_ff} + prod_ext);
      end
      if (cmd.wall_x) begin
         hit_x_in = lo_x | hi_x;
         if (lo_x) begin
            px_in = lo_clamp[VAL_W-1:0];
         end else if (hi_x) begin
            px_in = hi_clamp[VAL_W-1:0];
         end
      end
      if (cmd.wall_y) begin
         hit_y_in = lo_y | hi_y;
         if (lo_y) begin
            py_in = lo_clamp[VAL_W-1:0];
         end else if (hi_y) begin
            py_in = hi_clamp[VAL_W-1:0];
         end
      end
      if (cmd.bounce_x && hit_x_ff) begin
         vx_in = sat_val(prod_ext);
      end
      if (cmd.bounce_y && hit_y_ff) begin
         vy_in = sat_val(prod_ext);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         vx_ff <= '0;
         vy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         px_ff <= px_in;
         py_ff <= py_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_step) begin
         step_ff <= req_time_step;
      end
      prod_ff  <= prod_in;
      hit_x_ff <= hit_x_in;
      hit_y_ff <= hit_y_in;
      if (cmd.out_load) begin
         out_px_ff <= px_ff;
         out_py_ff <= py_ff;
         out_vx_ff <= vx_ff;
         out_vy_ff <= vy_ff;
      end
   end

endmodule

// ----- hw/rtl/bouncing_ball_step_top.sv -----
// Bouncing ball, one Euler step per tick, state kept in signed Q3.16.
//
// req_ch carries one request: kind selects a tick (advance by time_step) or
// a load (set position and velocity from load_x/y/vx/vy). rsp_ch returns one
// result per request holding the new position and velocity. Both channels
// move an item when valid and ready are high at a rising clock edge.
// The APB port holds gravity, bounce damping and ball radius; write it only
// while no request is in flight.
//
// A load goes from idle straight to the output state; a tick first walks seven
// steps through one shared 21x18 multiplier (three Euler products, then one
// damping product per axis). A request is taken only in the idle state, so
// the block takes no new request until the last one has reached its output.
// A result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the block before its next result.
// Synchronous reset clears position and velocity to zero and restores the
// register defaults.
module bouncing_ball_step_top (
   input  logic                       clock,
   input  logic                       reset,
   bbs_req_if.sink                    req_ch,
   bbs_rsp_if.source                  rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bbs_pkg::ADDR_W-1:0] paddr,
   input  logic [bbs_pkg::DATA_W-1:0] pwdata,
   output logic [bbs_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import bbs_pkg::*;

   bbs_cfg_type    cfg;
   bbs_cmd_type    cmd;
   bbs_status_type status;
   bbs_state_type  state;

   bbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   bbs_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg),
      .req_time_step (req_ch.time_step),
      .req_load_x    (req_ch.load_x),
      .req_load_y    (req_ch.load_y),
      .req_load_vx   (req_ch.load_vx),
      .req_load_vy   (req_ch.load_vy),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_pos_x     (rsp_ch.pos_x),
      .rsp_pos_y     (rsp_ch.pos_y),
      .rsp_vel_x     (rsp_ch.vel_x),
      .rsp_vel_y     (rsp_ch.vel_y)
   );

`ifndef ASSERT_OFF
   a_load_to_out: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.kind == KIND_LOAD) |=> state == ST_OUT)
      else $error("load request did not go straight to output");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state == ST_OUT))
      else $error("result raised outside the output state");

   a_tick_walk: assert property (@(posedge clock) disable iff (reset)
      (state == ST_ADD_G) |=> state == ST_WALL_X ##1 state == ST_WALL_Y)
      else $error("tick sequence skipped a wall step");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");
`endif

endmodule
